@@ rtl/core/dtts_pkg.sv @@
// ----------------------------------------------------------------------------
// dtts_pkg
// Shared types, codes and the unit word table for the duration text parser.
// ----------------------------------------------------------------------------
package dtts_pkg;

  // Parse phases of the character scanner.
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_MID    = 3'd3;
  localparam logic [2:0] PH_UNIT   = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;
  localparam logic [2:0] PH_BAD    = 3'd6;
  localparam logic [2:0] PH_STOP   = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_FORMAT   = 2'd2;

  // Longest unit word in the table, and the width of a unit factor.
  localparam int UNIT_WORD_MAX = 7;
  localparam int FACTOR_W      = 25;
  localparam int UNIT_COUNT    = 23;

  localparam logic [FACTOR_W-1:0] F_SEC  = 25'd1;
  localparam logic [FACTOR_W-1:0] F_MIN  = 25'd60;
  localparam logic [FACTOR_W-1:0] F_HOUR = 25'd3600;
  localparam logic [FACTOR_W-1:0] F_DAY  = 25'd86400;
  localparam logic [FACTOR_W-1:0] F_WEEK = 25'd604800;
  localparam logic [FACTOR_W-1:0] F_YEAR = 25'd31536000;

  // Unit words, right-aligned with the first letter in the highest used byte.
  localparam logic [8*UNIT_WORD_MAX-1:0] UNIT_TEXT [UNIT_COUNT] = '{
    "s", "m", "h", "d", "w", "y", "hr",
    "sec", "min", "hrs", "day", "wks", "yrs",
    "secs", "hour", "days", "week", "year",
    "hours", "weeks", "years", "second", "seconds"
  };

  localparam logic [3:0] UNIT_LEN [UNIT_COUNT] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd6, 4'd7
  };

  localparam logic [FACTOR_W-1:0] UNIT_FACTOR [UNIT_COUNT] = '{
    F_SEC, F_MIN, F_HOUR, F_DAY, F_WEEK, F_YEAR, F_HOUR,
    F_SEC, F_MIN, F_HOUR, F_DAY, F_WEEK, F_YEAR,
    F_SEC, F_HOUR, F_DAY, F_WEEK, F_YEAR,
    F_HOUR, F_WEEK, F_YEAR, F_SEC, F_SEC
  };

  typedef logic [UNIT_WORD_MAX-1:0][7:0] letter_row_t;

  // Parser state captured on the last character of a text.
  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic        ovf;
    logic        minus;
    letter_row_t letters;
    logic [3:0]  count;
  } snap_t;

  // Signed base value, factor and early status after the unit lookup.
  typedef struct packed {
    logic [1:0]          status;
    logic [63:0]         base;
    logic [FACTOR_W-1:0] factor;
  } scaled_t;

  // Partial products of base times factor.
  typedef struct packed {
    logic [1:0]             status;
    logic [FACTOR_W+31:0]   lo;
    logic [FACTOR_W+31:0]   hi;
  } partial_t;

  // Looks up the unit word; zero means the word is unknown.
  function automatic logic [FACTOR_W-1:0] unit_factor(input letter_row_t letters,
                                                     input logic [3:0] count);
    logic [FACTOR_W-1:0]          f;
    logic                         hit;
    logic [8*UNIT_WORD_MAX-1:0]   aligned;
    f = '0;
    if (count == 4'd0) begin
      f = F_SEC;
    end else begin
      for (int i = 0; i < UNIT_COUNT; i++) begin
        aligned = UNIT_TEXT[i] << (8 * (UNIT_WORD_MAX - int'(UNIT_LEN[i])));
        hit = (count == UNIT_LEN[i]);
        for (int j = 0; j < UNIT_WORD_MAX; j++) begin
          if ((j < int'(UNIT_LEN[i])) &&
              (letters[j] != aligned[8*(UNIT_WORD_MAX-1-j) +: 8])) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          f = UNIT_FACTOR[i];
        end
      end
    end
    return f;
  endfunction

endpackage

@@ rtl/core/dtts_parser.sv @@
// ----------------------------------------------------------------------------
// dtts_parser
// Character scanner: one character per cycle when in_ready; captures the parse
// state on the last character of a text and restarts for the next text.
// ----------------------------------------------------------------------------
module dtts_parser #(
  parameter int MAX_UNIT_LEN = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           character,
  input  logic                 end_of_text,
  output logic                 snap_valid,
  input  logic                 snap_ready,
  output dtts_pkg::snap_t      snap
);

  localparam int LIDX_W = (MAX_UNIT_LEN > 1) ? $clog2(MAX_UNIT_LEN) : 1;

  logic [2:0]  phase;
  logic [63:0] acc;
  logic        ovf;
  logic        minus;
  logic [3:0]  count;
  logic [7:0]  letters [MAX_UNIT_LEN];

  logic [2:0]  phase_next;
  logic [63:0] acc_next;
  logic        ovf_next;
  logic        minus_next;
  logic [3:0]  count_next;
  logic        wr_en;
  logic [7:0]  wr_char;
  logic [LIDX_W-1:0] wr_idx;

  logic        is_ws, is_upper, is_letter, is_digit, accept, halted;
  logic [67:0] mac;
  logic        mac_ovf;
  dtts_pkg::letter_row_t row_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !snap_valid || snap_ready;

  // Character classes.
  assign is_ws     = (character == 8'd32) || (character >= 8'd9 && character <= 8'd13);
  assign is_upper  = (character >= 8'd65) && (character <= 8'd90);
  assign is_letter = is_upper || ((character >= 8'd97) && (character <= 8'd122));
  assign is_digit  = (character >= 8'd48) && (character <= 8'd57);
  assign halted    = ovf || (phase == dtts_pkg::PH_BAD) || (phase == dtts_pkg::PH_STOP);

  // Accumulator times ten plus the digit; any bit above 63 is an overflow.
  assign mac = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
               {64'd0, character[3:0] - 4'd0};
  assign mac_ovf = |mac[67:64];

  assign wr_char = character | 8'h20;
  assign wr_idx  = count[LIDX_W-1:0];

  // Next parse state for the current character.
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    minus_next = minus;
    count_next = count;
    wr_en      = 1'b0;
    if (!halted) begin
      if (character == 8'd0) begin
        if (phase == dtts_pkg::PH_LEAD || phase == dtts_pkg::PH_SIGN) begin
          phase_next = dtts_pkg::PH_BAD;
        end else begin
          phase_next = dtts_pkg::PH_STOP;
        end
      end else begin
        case (phase)
          dtts_pkg::PH_LEAD: begin
            if (is_ws) begin
              phase_next = phase;
            end else if (character == 8'd43 || character == 8'd45) begin
              minus_next = (character == 8'd45);
              phase_next = dtts_pkg::PH_SIGN;
            end else if (is_digit) begin
              if (mac_ovf) ovf_next = 1'b1;
              else acc_next = mac[63:0];
              phase_next = dtts_pkg::PH_DIGITS;
            end else begin
              phase_next = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_SIGN: begin
            if (is_digit) begin
              if (mac_ovf) ovf_next = 1'b1;
              else acc_next = mac[63:0];
              phase_next = dtts_pkg::PH_DIGITS;
            end else begin
              phase_next = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_DIGITS, dtts_pkg::PH_MID: begin
            if (phase == dtts_pkg::PH_DIGITS && is_digit) begin
              if (mac_ovf) ovf_next = 1'b1;
              else acc_next = mac[63:0];
            end else if (is_ws) begin
              phase_next = dtts_pkg::PH_MID;
            end else if (is_letter) begin
              // The unit word always starts empty here.
              phase_next = dtts_pkg::PH_UNIT;
              wr_en      = 1'b1;
              count_next = count + 4'd1;
            end else begin
              phase_next = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_UNIT: begin
            if (is_letter) begin
              if (count >= 4'(MAX_UNIT_LEN)) begin
                phase_next = dtts_pkg::PH_BAD;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 4'd1;
              end
            end else if (is_ws) begin
              phase_next = dtts_pkg::PH_TRAIL;
            end else begin
              phase_next = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_TRAIL: begin
            if (!is_ws) phase_next = dtts_pkg::PH_BAD;
          end
          default: begin
            phase_next = dtts_pkg::PH_BAD;
          end
        endcase
      end
    end
  end

  // Unit letters as they stand after this character.
  always_comb begin
    for (int j = 0; j < dtts_pkg::UNIT_WORD_MAX; j++) begin
      if (wr_en && wr_idx == LIDX_W'(j)) row_next[j] = wr_char;
      else row_next[j] = letters[j];
    end
  end

  // Parser state; the last character of a text restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dtts_pkg::PH_LEAD;
      acc   <= '0;
      ovf   <= 1'b0;
      minus <= 1'b0;
      count <= '0;
    end else if (accept) begin
      if (end_of_text) begin
        phase <= dtts_pkg::PH_LEAD;
        acc   <= '0;
        ovf   <= 1'b0;
        minus <= 1'b0;
        count <= '0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        ovf   <= ovf_next;
        minus <= minus_next;
        count <= count_next;
      end
    end
  end

  // Unit letter store.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      letters[wr_idx] <= wr_char;
    end
  end

  // Captured state for the result stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && end_of_text) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_text) begin
      snap.phase   <= phase_next;
      snap.acc     <= acc_next;
      snap.ovf     <= ovf_next;
      snap.minus   <= minus_next;
      snap.letters <= row_next;
      snap.count   <= count_next;
    end
  end

endmodule

@@ rtl/core/dtts_unit.sv @@
// ----------------------------------------------------------------------------
// dtts_unit
// Unit word lookup, sign handling and early status for a finished text.
// ----------------------------------------------------------------------------
module dtts_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  dtts_pkg::snap_t      snap,
  output logic                 scl_valid,
  input  logic                 scl_ready,
  output dtts_pkg::scaled_t    scl
);

  logic [dtts_pkg::FACTOR_W-1:0] factor;
  logic [1:0]                    status;
  logic                          accept;

  assign snap_ready = !scl_valid || scl_ready;
  assign accept     = snap_valid && snap_ready;
  assign factor     = dtts_pkg::unit_factor(snap.letters, snap.count);

  // Digit overflow wins over any format error.
  always_comb begin
    if (snap.ovf) begin
      status = dtts_pkg::ST_OVERFLOW;
    end else if (snap.phase == dtts_pkg::PH_LEAD || snap.phase == dtts_pkg::PH_SIGN ||
                 snap.phase == dtts_pkg::PH_BAD) begin
      status = dtts_pkg::ST_FORMAT;
    end else if (factor == '0) begin
      status = dtts_pkg::ST_FORMAT;
    end else begin
      status = dtts_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_valid <= 1'b0;
    end else if (accept) begin
      scl_valid <= 1'b1;
    end else if (scl_ready) begin
      scl_valid <= 1'b0;
    end
  end

  // A minus sign negates modulo 2^64.
  always_ff @(posedge clk) begin
    if (accept) begin
      scl.status <= status;
      scl.base   <= snap.minus ? (64'd0 - snap.acc) : snap.acc;
      scl.factor <= factor;
    end
  end

endmodule

@@ rtl/core/dtts_mul.sv @@
// ----------------------------------------------------------------------------
// dtts_mul
// Multiplies the base by the unit factor in two 32-bit halves, then joins the
// halves and checks the product for overflow.
// ----------------------------------------------------------------------------
module dtts_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 scl_valid,
  output logic                 scl_ready,
  input  dtts_pkg::scaled_t    scl,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           res_status,
  output logic [63:0]          res_seconds
);

  dtts_pkg::partial_t part;
  logic               accept;
  logic [64:0]        sum;
  logic               prod_ovf;

  assign scl_ready = !res_valid || res_ready;
  assign accept    = scl_valid && scl_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Partial products of the low and high halves.
  always_ff @(posedge clk) begin
    if (accept) begin
      part.status <= scl.status;
      part.lo     <= scl.base[31:0] * scl.factor;
      part.hi     <= scl.base[63:32] * scl.factor;
    end
  end

  // Join the halves; any high product bit above 63 is an overflow.
  assign sum      = {8'd0, part.lo} + {1'b0, part.hi[31:0], 32'd0};
  assign prod_ovf = (|part.hi[dtts_pkg::FACTOR_W+31:32]) || sum[64];

  always_comb begin
    if (part.status != dtts_pkg::ST_OK) begin
      res_status  = part.status;
      res_seconds = '0;
    end else if (prod_ovf) begin
      res_status  = dtts_pkg::ST_OVERFLOW;
      res_seconds = '0;
    end else begin
      res_status  = dtts_pkg::ST_OK;
      res_seconds = sum[63:0];
    end
  end

endmodule

@@ rtl/core/duration_text_to_seconds.sv @@
// ----------------------------------------------------------------------------
// duration_text_to_seconds
// Turns a duration text such as "  5 min " into a count of seconds.
// ----------------------------------------------------------------------------
// The block takes one character word per cycle while in_ready is high and
// gives one result word for each text. On the character that carries
// end_of_text the parser captures its state; then the unit stage looks up the
// unit word, the multiply stage forms two 32-bit partial products, and the
// output register holds the joined and checked product. Every stage holds one
// text, so while no stage is held the rate is set by the character scanner at
// one character per cycle, and a new text may start on the cycle after the
// previous one ends. Status is 0 for ok, 1 for overflow and 2 for a malformed
// text; seconds_value is zero unless the status is ok.
// ----------------------------------------------------------------------------
module duration_text_to_seconds #(
  parameter int MAX_UNIT_LEN = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] seconds_value
);

  logic                 snap_valid, snap_ready;
  dtts_pkg::snap_t      snap;
  logic                 scl_valid, scl_ready;
  dtts_pkg::scaled_t    scl;
  logic                 res_valid, res_ready;
  logic [1:0]           res_status;
  logic [63:0]          res_seconds;
  logic                 res_accept;

  dtts_parser #(
    .MAX_UNIT_LEN(MAX_UNIT_LEN)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .character(character),
    .end_of_text(end_of_text),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap(snap)
  );

  dtts_unit u_unit (
    .clk(clk),
    .rst(rst),
    .snap_valid(snap_valid),
    .snap_ready(snap_ready),
    .snap(snap),
    .scl_valid(scl_valid),
    .scl_ready(scl_ready),
    .scl(scl)
  );

  dtts_mul u_mul (
    .clk(clk),
    .rst(rst),
    .scl_valid(scl_valid),
    .scl_ready(scl_ready),
    .scl(scl),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_status(res_status),
    .res_seconds(res_seconds)
  );

  assign res_ready  = !out_valid || out_ready;
  assign res_accept = res_valid && res_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_accept) begin
      status        <= res_status;
      seconds_value <= res_seconds;
    end
  end

endmodule

@@ tb/duration_text_to_seconds_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// duration_text_to_seconds_tb
// Feeds duration texts one character word at a time. A short directed list
// comes first, then random texts. Most random texts are well formed, with
// random signs, digit counts and unit words in mixed case. The rest are broken
// texts and raw byte noise. A scoreboard predicts the status and the seconds
// of every text and checks each result word in order. Both handshakes idle at
// random, the receiver holds off for long stretches, and the sender sometimes
// waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module duration_text_to_seconds_tb;

  localparam int LETTER_MAX   = 7;
  localparam int GAP_MAX      = 18;
  localparam int RANDOM_CHARS = 1100;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int NAME_COUNT   = 23;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       drain;
  } char_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] secs;
  } duration_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'd0;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] seconds_value;

  char_word_t char_q[$];
  duration_t  duration_q[$];
  logic [7:0] text_buf[$];
  int         queued = 0;
  int         fails = 0;

  string unit_names[NAME_COUNT] = '{
    "s", "sec", "secs", "second", "seconds", "m", "min", "h", "hr", "hrs",
    "hour", "hours", "d", "day", "days", "w", "wks", "week", "weeks",
    "y", "yrs", "year", "years"
  };

  // Scanner state of the scoreboard.
  logic [2:0]  scan_phase;
  logic [63:0] scan_num;
  logic        scan_ovf;
  logic        scan_neg;
  logic [55:0] scan_unit;
  logic [3:0]  scan_len;

  always #2 clk = ~clk;

  duration_text_to_seconds dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .character     (character),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .seconds_value (seconds_value)
  );

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  // A byte that is sometimes anything and sometimes a character the scanner cares about.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, 255));
      1: return blank_char();
      2: return 8'($urandom_range(48, 57));
      3: return 8'($urandom_range(0, 1) ? $urandom_range(97, 122) : $urandom_range(65, 90));
      default: return $urandom_range(0, 1) ? "+" : "-";
    endcase
  endfunction

  // Idle cycles for one word: none, uniform, or mostly none.
  function automatic int unsigned gap_draw(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, GAP_MAX);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
    endcase
  endfunction

  task automatic clear_scan();
    scan_phase = dtts_pkg::PH_LEAD;
    scan_num   = 64'd0;
    scan_ovf   = 1'b0;
    scan_neg   = 1'b0;
    scan_unit  = 56'd0;
    scan_len   = 4'd0;
  endtask

  // Decimal accumulate; an overflowing digit leaves the value as it was.
  task automatic take_digit(input logic [7:0] c);
    logic [127:0] wide;
    wide = {64'd0, scan_num} * 128'd10 + {120'd0, c - 8'd48};
    if (wide[127:64] != 64'd0) begin
      scan_ovf = 1'b1;
    end else begin
      scan_num = wide[63:0];
    end
  endtask

  // Unit letters are folded to lower case and packed with the last letter lowest.
  task automatic take_letter(input logic [7:0] c);
    logic [7:0] lc;
    if (scan_len >= LETTER_MAX) begin
      scan_phase = dtts_pkg::PH_BAD;
    end else begin
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      scan_unit = {scan_unit[47:0], lc};
      scan_len++;
    end
  endtask

  // Steps the scoreboard by one accepted character word.
  task automatic scan_char(input logic [7:0] c, input logic last);
    logic [127:0] wide;
    logic [63:0]  base;
    logic [63:0]  mult;
    duration_t    res;
    if (!(scan_ovf || scan_phase == dtts_pkg::PH_BAD || scan_phase == dtts_pkg::PH_STOP)) begin
      if (c == 8'd0) begin
        if (scan_phase == dtts_pkg::PH_LEAD || scan_phase == dtts_pkg::PH_SIGN) begin
          scan_phase = dtts_pkg::PH_BAD;
        end else begin
          scan_phase = dtts_pkg::PH_STOP;
        end
      end else begin
        case (scan_phase)
          dtts_pkg::PH_LEAD: begin
            if (is_blank(c)) begin
            end else if (c == "+" || c == "-") begin
              scan_neg = (c == "-");
              scan_phase = dtts_pkg::PH_SIGN;
            end else if (is_num(c)) begin
              take_digit(c);
              scan_phase = dtts_pkg::PH_DIGITS;
            end else begin
              scan_phase = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_SIGN: begin
            if (is_num(c)) begin
              take_digit(c);
              scan_phase = dtts_pkg::PH_DIGITS;
            end else begin
              scan_phase = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_DIGITS, dtts_pkg::PH_MID: begin
            if (scan_phase == dtts_pkg::PH_DIGITS && is_num(c)) begin
              take_digit(c);
            end else if (is_blank(c)) begin
              scan_phase = dtts_pkg::PH_MID;
            end else if (is_alpha(c)) begin
              scan_phase = dtts_pkg::PH_UNIT;
              take_letter(c);
            end else begin
              scan_phase = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_UNIT: begin
            if (is_alpha(c)) begin
              take_letter(c);
            end else if (is_blank(c)) begin
              scan_phase = dtts_pkg::PH_TRAIL;
            end else begin
              scan_phase = dtts_pkg::PH_BAD;
            end
          end
          dtts_pkg::PH_TRAIL: begin
            if (!is_blank(c)) begin
              scan_phase = dtts_pkg::PH_BAD;
            end
          end
          default: begin
            scan_phase = dtts_pkg::PH_BAD;
          end
        endcase
      end
    end

    // The last word of a text produces the expected result and restarts the scanner.
    if (last) begin
      res.status = dtts_pkg::ST_OK;
      res.secs = 64'd0;
      if (scan_ovf) begin
        res.status = dtts_pkg::ST_OVERFLOW;
      end else if (scan_phase == dtts_pkg::PH_LEAD || scan_phase == dtts_pkg::PH_SIGN ||
                   scan_phase == dtts_pkg::PH_BAD) begin
        res.status = dtts_pkg::ST_FORMAT;
      end else begin
        case (scan_unit)
          56'd0, "s", "sec", "secs", "second", "seconds": mult = 64'd1;
          "m", "min": mult = 64'd60;
          "h", "hr", "hrs", "hour", "hours": mult = 64'd3600;
          "d", "day", "days": mult = 64'd86400;
          "w", "wks", "week", "weeks": mult = 64'd604800;
          "y", "yrs", "year", "years": mult = 64'd31536000;
          default: mult = 64'd0;
        endcase
        base = scan_neg ? -scan_num : scan_num;
        wide = {64'd0, base} * {64'd0, mult};
        if (mult == 64'd0) begin
          res.status = dtts_pkg::ST_FORMAT;
        end else if (wide[127:64] != 64'd0) begin
          res.status = dtts_pkg::ST_OVERFLOW;
        end else begin
          res.secs = wide[63:0];
        end
      end
      duration_q.push_back(res);
      clear_scan();
    end
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_buf.push_back(s[i]);
    end
  endtask

  // Moves the text being built into the send queue, end flag on its last byte.
  task automatic flush_text(input logic hold);
    char_word_t w;
    foreach (text_buf[i]) begin
      w.ch = text_buf[i];
      w.last = (i == text_buf.size() - 1);
      w.drain = hold && (i == 0);
      char_q.push_back(w);
    end
    queued += text_buf.size();
    text_buf.delete();
  endtask

  // Sender: offers queued character words and feeds accepted ones to the scoreboard.
  int unsigned send_gap = 0;
  int          send_mode = 1;
  char_word_t  next_char;

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_char(character, end_of_text);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() != 0 && !(char_q[0].drain && duration_q.size() != 0)) begin
          next_char = char_q.pop_front();
          character <= next_char.ch;
          end_of_text <= next_char.last;
          in_valid <= 1'b1;
          if ($urandom_range(0, 59) == 0) begin
            send_mode = $urandom_range(0, 2);
          end
          send_gap = gap_draw(send_mode);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  int unsigned recv_gap = 0;
  int unsigned recv_hold = 0;
  int unsigned delivered = 0;
  int          recv_mode = 1;
  duration_t   want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (duration_q.size() == 0) begin
          $error("unexpected result word: status %0d, seconds_value %0d", status, seconds_value);
          fails++;
        end else begin
          want = duration_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (seconds_value !== want.secs) begin
            $error("seconds_value: expected %0d, got %0d", want.secs, seconds_value);
            fails++;
          end
        end
        delivered++;
        if (delivered == 30 || delivered == 120) begin
          recv_hold = HOLD_CYCLES;
        end
        if ($urandom_range(0, 19) == 0) begin
          recv_mode = $urandom_range(0, 2);
        end
        recv_gap = gap_draw(recv_mode);
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Builds all texts, releases reset, and waits for the last result word.
  initial begin : stimulus
    int    texts;
    int    r;
    int    n;
    int    pos;
    string w;
    texts = 0;

    // Empty text, blank text, sign alone, sign then space.
    text_buf.push_back(8'h00);
    flush_text(1'b0);
    add_str(" ");
    flush_text(1'b0);
    add_str("-");
    flush_text(1'b0);
    add_str("+ ");
    flush_text(1'b0);
    // Upper-case unit, unknown unit, a byte above 127.
    add_str("7Y");
    flush_text(1'b0);
    add_str("9q");
    flush_text(1'b0);
    add_str("1");
    text_buf.push_back(8'hFF);
    flush_text(1'b0);
    // Zero byte ends the text early; a unit word one letter too long.
    add_str("3");
    text_buf.push_back(8'h00);
    add_str("x");
    flush_text(1'b0);
    add_str("1secondss");
    flush_text(1'b0);

    while (queued < RANDOM_CHARS) begin
      texts++;
      r = $urandom_range(0, 19);
      if (r < 3) begin
        n = $urandom_range(1, 6);
        repeat (n) text_buf.push_back(noise_char());
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n) text_buf.push_back(blank_char());
        end
        case ($urandom_range(0, 5))
          0: text_buf.push_back("+");
          1: text_buf.push_back("-");
          default: ;
        endcase
        n = $urandom_range(0, 19);
        if (n < 14) begin
          n = $urandom_range(1, 5);
        end else if (n < 18) begin
          n = $urandom_range(6, 17);
        end else begin
          n = $urandom_range(18, 22);
        end
        repeat (n) text_buf.push_back(8'($urandom_range(48, 57)));
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, 2);
          repeat (n) text_buf.push_back(blank_char());
        end
        n = $urandom_range(0, 19);
        if (n < 12) begin
          w = unit_names[$urandom_range(0, NAME_COUNT - 1)];
          for (int i = 0; i < w.len(); i++) begin
            text_buf.push_back(($urandom_range(0, 3) == 0) ? w[i] - 8'd32 : w[i]);
          end
        end else if (n < 15) begin
          n = $urandom_range(1, 9);
          repeat (n) begin
            text_buf.push_back(8'($urandom_range(0, 1) ? $urandom_range(97, 122)
                                                       : $urandom_range(65, 90)));
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 2);
          repeat (n) text_buf.push_back(blank_char());
        end
        // Some texts get one byte overwritten to break them.
        if (r < 5) begin
          pos = $urandom_range(0, text_buf.size() - 1);
          text_buf[pos] = noise_char();
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        text_buf.push_back(8'h00);
        n = $urandom_range(0, 3);
        repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      flush_text(texts % 50 == 0);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (char_q.size() != 0 || in_valid || duration_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("duration_text_to_seconds: match");
    end else begin
      $display("duration_text_to_seconds: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("duration_text_to_seconds: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dtts_pkg.sv
rtl/core/dtts_parser.sv
rtl/core/dtts_unit.sv
rtl/core/dtts_mul.sv
rtl/core/duration_text_to_seconds.sv
tb/duration_text_to_seconds_tb.sv
